FILE: src/mtwa_pkg.sv
package mtwa_pkg;

   // sample and result layout
   localparam int AXES            = 6;
   localparam int ACC_AXES        = 3;
   localparam int OUT_W           = 16;
   localparam int AXIS_W          = 3;

   // configuration registers
   localparam int THR_W           = 16;
   localparam int WLEN_W          = 7;
   localparam int WLEN_MAX        = 2 ** WLEN_W - 1;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 2'd1;

   localparam logic [THR_W-1:0]  THR_RESET  = 16'd8192;
   localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd75;

   // defaults for the top level parameters
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_MAX_WINDOW  = 127;

endpackage

FILE: src/mtwa_div.sv
module mtwa_div
   import mtwa_pkg::*;
#(
   parameter int DVD_W = 23,
   parameter int DVS_W = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]        divisor,
   output logic                    done,
   output logic signed [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [DVD_W-1:0]  mag_ff, mag_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    rem_sh;
   logic              fits;

   // one quotient bit per cycle on the magnitude, sign fixed at the end
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, mag_ff[DVD_W-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W);
         neg_in  = dividend[DVD_W-1];
         mag_in  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         mag_in  = {mag_ff[DVD_W-2:0], fits};
         rem_in  = fits ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

endmodule

FILE: src/motion_triggered_window_averager.sv
// Motion-triggered window averager for a six-axis IMU sample stream.
// req_ carries one sample per word: three accelerometer and three gyro counts.
// While no capture runs, the accelerometer is compared axis by axis with the
// previous sample; a change above motion_threshold opens a capture window.
// Samples in the window are summed, and when window_length samples are in
// (at least 1, at most MAX_WINDOW), one rsp_ word with six truncated averages is sent.
// csr_ writes motion_threshold (index 0) or window_length (index 1); write
// only while no sample is in work.
// Work per sample is set by the shared compare/add step and the divider:
//   no capture: compare over the three accelerometer axes; on a trigger the
//   six-axis add follows; inside a window: the add only; window end: six serial
//   divisions follow the add. req_tready is high only between samples.
// The averages wait in an output register; a stalled receiver holds back the
// next window end only, not the samples in between.
// Reset (synchronous) restores the register defaults, clears the previous
// sample to zero and ends any capture.
module motion_triggered_window_averager
   import mtwa_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, zero fill
   input  logic [((AXES*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mean_accel_x, mean_accel_y, mean_accel_z, mean_rate_x, mean_rate_y, mean_rate_z
   output logic [AXES*OUT_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WIN_CAP = (MAX_WINDOW < WLEN_MAX) ? MAX_WINDOW : WLEN_MAX;
   localparam int CNT_W   = $clog2(WIN_CAP + 1);
   localparam int SUM_W   = SAMPLE_BITS + CNT_W;
   localparam int DIFF_W  = SAMPLE_BITS + 1;
   localparam int CMP_W   = (DIFF_W > THR_W) ? DIFF_W : THR_W;
   localparam int EXT_W   = (SUM_W > OUT_W) ? SUM_W : OUT_W;
   localparam logic [WLEN_W-1:0] WIN_CAP_V = WLEN_W'(WIN_CAP);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CMP  = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [AXIS_W-1:0]        axis_ff, axis_in;
   logic                     moved_ff, moved_in;
   logic                     capt_ff, capt_in;
   logic                     clear_ff, clear_in;
   logic                     go_ff, go_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [THR_W-1:0]         thr_ff;
   logic [WLEN_W-1:0]        wlen_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [AXES*OUT_W-1:0]    rsp_data_ff, rsp_data_in;
   logic signed [SAMPLE_BITS-1:0] smp_ff [AXES];
   logic signed [SAMPLE_BITS-1:0] smp_in [AXES];
   logic signed [SAMPLE_BITS-1:0] last_ff [ACC_AXES];
   logic signed [SUM_W-1:0]  sum_ff [AXES];
   logic [OUT_W-1:0]         mean_ff [AXES];

   logic                     req_take;
   logic                     last_upd;
   logic                     sum_wr;
   logic signed [SUM_W-1:0]  sum_new;
   logic signed [SUM_W-1:0]  sum_base;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        abs_diff;
   logic                     hit;
   logic [CNT_W-1:0]         cnt_next;
   logic [WLEN_W-1:0]        limit;
   logic                     win_end;
   logic                     div_done;
   logic signed [SUM_W-1:0]  div_quo;
   logic signed [EXT_W-1:0]  quo_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;

   // unpack the sample word
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         smp_in[i] = req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
   end

   // shared compare path: absolute accelerometer change against threshold
   assign diff     = DIFF_W'(smp_ff[axis_ff]) - DIFF_W'(last_ff[axis_ff[1:0]]);
   assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign hit      = CMP_W'(abs_diff) > CMP_W'(thr_ff);

   // shared add path: one axis sum per cycle
   assign sum_base = clear_ff ? '0 : sum_ff[axis_ff];
   assign sum_new  = sum_base + SUM_W'(smp_ff[axis_ff]);

   // window count and limit
   assign cnt_next = (clear_ff ? '0 : cnt_ff) + 1'b1;
   assign limit    = (wlen_ff > WIN_CAP_V) ? WIN_CAP_V : wlen_ff;
   assign win_end  = WLEN_W'(cnt_next) >= limit;

   mtwa_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (sum_ff[axis_ff]),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign quo_ext = EXT_W'(div_quo);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      moved_in     = moved_ff;
      capt_in      = capt_ff;
      clear_in     = clear_ff;
      go_in        = 1'b0;
      cnt_in       = cnt_ff;
      last_upd     = 1'b0;
      sum_wr       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      for (int i = 0; i < AXES; i++) begin
         rsp_data_in[i*OUT_W +: OUT_W] = (state_ff == ST_EMIT) ? mean_ff[i]
                                                              : rsp_data_ff[i*OUT_W +: OUT_W];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               axis_in  = '0;
               moved_in = 1'b0;
               state_in = capt_ff ? ST_ACC : ST_CMP;
            end
         end
         ST_CMP: begin
            if (axis_ff == AXIS_W'(ACC_AXES - 1)) begin
               axis_in = '0;
               if (moved_ff || hit) begin
                  capt_in  = 1'b1;
                  clear_in = 1'b1;
                  state_in = ST_ACC;
               end else begin
                  last_upd = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               moved_in = moved_ff || hit;
               axis_in  = axis_ff + 1'b1;
            end
         end
         ST_ACC: begin
            sum_wr = 1'b1;
            if (axis_ff == AXIS_W'(AXES - 1)) begin
               clear_in = 1'b0;
               cnt_in   = cnt_next;
               last_upd = 1'b1;
               axis_in  = '0;
               if (win_end) begin
                  capt_in  = 1'b0;
                  go_in    = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (axis_ff == AXIS_W'(AXES - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  axis_in = axis_ff + 1'b1;
                  go_in   = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rsp_data_in = rsp_data_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         moved_ff     <= 1'b0;
         capt_ff      <= 1'b0;
         clear_ff     <= 1'b0;
         go_ff        <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ACC_AXES; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         moved_ff     <= moved_in;
         capt_ff      <= capt_in;
         clear_ff     <= clear_in;
         go_ff        <= go_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (last_upd) begin
            for (int i = 0; i < ACC_AXES; i++) begin
               last_ff[i] <= smp_ff[i];
            end
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_RESET;
         wlen_ff <= WLEN_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_ff  <= csr_wdata[THR_W-1:0];
            CSR_WINDOW:    wlen_ff <= csr_wdata[WLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int i = 0; i < AXES; i++) begin
            smp_ff[i] <= smp_in[i];
         end
      end
      if (sum_wr) begin
         sum_ff[axis_ff] <= sum_new;
      end
      if (div_done) begin
         mean_ff[axis_ff] <= quo_ext[OUT_W-1:0];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a result word only appears out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result word raised outside emit step");

   // a capture only ends on the last axis of the accumulate step
   a_capt_end: assert property (@(posedge clock) disable iff (reset)
      $fell(capt_ff) |-> $past(state_ff == ST_ACC) && state_ff == ST_DIV)
      else $error("capture ended outside accumulate step");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider done outside divide step");

   // a taken sample always starts the compare or accumulate step
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_CMP || state_ff == ST_ACC)
      else $error("sample taken but no work started");

endmodule

FILE: test/motion_triggered_window_averager_test.sv
`timescale 1ns / 1ps

module motion_triggered_window_averager_test
   import mtwa_pkg::*;
();

   localparam int LANE_W       = DEF_SAMPLE_BITS;
   localparam int WORD_W       = ((AXES * LANE_W + 7) / 8) * 8;
   localparam int RSP_W        = AXES * OUT_W;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 2000;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int PHASE_ITEMS  = 400;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   // predicts the window averages and checks them in order
   class window_scoreboard;
      logic [THR_W-1:0]        threshold;
      logic [WLEN_W-1:0]       window_len;
      logic signed [LANE_W-1:0] prev_accel [ACC_AXES];
      bit                      capturing;
      int                      win_count;
      longint                  axis_sum [AXES];
      logic [RSP_W-1:0]        mean_queue [$];
      int                      errors;
      string                   field_name [AXES];

      function new();
         threshold    = THR_RESET;
         window_len   = WLEN_RESET;
         capturing    = 1'b0;
         win_count    = 0;
         errors       = 0;
         foreach (prev_accel[i]) prev_accel[i] = '0;
         foreach (axis_sum[i]) axis_sum[i] = 0;
         field_name = '{"mean_accel_x", "mean_accel_y", "mean_accel_z",
                        "mean_rate_x", "mean_rate_y", "mean_rate_z"};
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_THRESHOLD) begin
            threshold = value[THR_W-1:0];
         end else if (idx == CSR_WINDOW) begin
            window_len = value[WLEN_W-1:0];
         end
      endfunction

      function void note_sample(input logic [WORD_W-1:0] word);
         logic signed [LANE_W-1:0] s [AXES];
         logic [RSP_W-1:0]         means;
         longint                   diff;
         longint                   avg;
         bit                       moved;
         int                       limit;
         foreach (s[i]) s[i] = word[i*LANE_W +: LANE_W];
         // motion detect only while no window is open
         if (!capturing) begin
            moved = 1'b0;
            for (int i = 0; i < ACC_AXES; i++) begin
               diff = longint'(s[i]) - longint'(prev_accel[i]);
               if (diff < 0) diff = -diff;
               if (diff > longint'(threshold)) moved = 1'b1;
            end
            if (moved) begin
               capturing    = 1'b1;
               win_count    = 0;
               foreach (axis_sum[i]) axis_sum[i] = 0;
            end
         end
         // accumulate and close the window at its length
         if (capturing) begin
            foreach (axis_sum[i]) axis_sum[i] += longint'(s[i]);
            win_count++;
            limit = (window_len > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : int'(window_len);
            if (win_count >= limit) begin
               for (int i = 0; i < AXES; i++) begin
                  avg = axis_sum[i] / longint'(win_count);
                  means[i*OUT_W +: OUT_W] = avg[OUT_W-1:0];
               end
               mean_queue.push_back(means);
               capturing = 1'b0;
            end
         end
         for (int i = 0; i < ACC_AXES; i++) prev_accel[i] = s[i];
      endfunction

      function void check_means(input logic [RSP_W-1:0] word);
         logic [RSP_W-1:0] want;
         if (mean_queue.size() == 0) begin
            errors++;
            $display("%0t: result word %h with no window pending", $time, word);
            return;
         end
         want = mean_queue.pop_front();
         for (int i = 0; i < AXES; i++) begin
            if (word[i*OUT_W +: OUT_W] !== want[i*OUT_W +: OUT_W]) begin
               errors++;
               $display("%0t: %s expected %0d got %0d", $time, field_name[i],
                        $signed(want[i*OUT_W +: OUT_W]), $signed(word[i*OUT_W +: OUT_W]));
            end
         end
      endfunction

      function int pending();
         return mean_queue.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic [WORD_W-1:0]     req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   window_scoreboard  sb;
   logic [WORD_W-1:0] last_word = '0;
   int                items_sent = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                hold_requests = 0;
   int                holds_served = 0;
   int                hold_left = 0;
   int                cycle_count = 0;

   motion_triggered_window_averager uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) sb.check_means(rsp_tdata);
   end

   function automatic logic [WORD_W-1:0] pack_sample(input logic [LANE_W-1:0] ax, ay, az,
                                                     gx, gy, gz);
      return {gz, gy, gx, az, ay, ax};
   endfunction

   // next sample: accel drifts around the last one, with occasional jumps
   function automatic logic [WORD_W-1:0] wander(input logic [WORD_W-1:0] prev);
      logic [WORD_W-1:0] w;
      int                spread;
      int                step;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: spread = 8;
         4, 5, 6:    spread = 256;
         7, 8:       spread = 4096;
         default:    spread = 0;
      endcase
      for (int i = 0; i < ACC_AXES; i++) begin
         if (spread == 0) begin
            w[i*LANE_W +: LANE_W] = LANE_W'($urandom);
         end else begin
            step = int'($urandom_range(0, 2 * spread)) - spread;
            w[i*LANE_W +: LANE_W] = prev[i*LANE_W +: LANE_W] + step[LANE_W-1:0];
         end
      end
      for (int i = ACC_AXES; i < AXES; i++) begin
         case ($urandom_range(0, 7))
            0:       w[i*LANE_W +: LANE_W] = 16'h7FFF;
            1:       w[i*LANE_W +: LANE_W] = 16'h8000;
            default: w[i*LANE_W +: LANE_W] = LANE_W'($urandom);
         endcase
      end
      return w;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic send_word(input logic [WORD_W-1:0] word);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_sample(word);
      last_word = word;
      items_sent++;
   endtask

   // stop sending, let every window come out and the block go quiet
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic directed_tests();
      // default threshold: a change of exactly 8192 does not trigger
      send_word(pack_sample(16'd8192, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'd0));
      send_word(pack_sample(16'd0, -16'sd8192, 16'd0, 16'd1, 16'hFFFF, 16'd0));
      wait_idle();

      // zero window length: every trigger emits its own sample
      write_csr(CSR_THRESHOLD, 16'd0);
      write_csr(CSR_WINDOW, 16'hFF80);
      send_word(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_word(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_word(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF));
      wait_idle();

      // writes to unused indexes change nothing
      write_csr(CSR_SPARE_LO, 16'h0005);
      write_csr(CSR_SPARE_HI, 16'hFFFF);
      send_word(pack_sample(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1));
      wait_idle();

      // max threshold: full-scale swings never trigger
      write_csr(CSR_THRESHOLD, 16'hFFFF);
      write_csr(CSR_WINDOW, 16'd127);
      send_word(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0));
      send_word(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'd0));
      send_word(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0));
      wait_idle();

      // one below max: triggers; three-sample window with negative truncation
      write_csr(CSR_THRESHOLD, 16'hFFFE);
      write_csr(CSR_WINDOW, 16'd3);
      send_word(pack_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd1));
      send_word(pack_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0));
      send_word(pack_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd0, 16'hFFFE));
      wait_idle();

      // jumps inside a window are ignored; then shorten the open window
      write_csr(CSR_THRESHOLD, 16'd100);
      write_csr(CSR_WINDOW, 16'd10);
      send_word(pack_sample(16'd0, 16'd0, 16'd0, 16'd5, 16'hFFF0, 16'd7));
      send_word(pack_sample(16'h7000, 16'd0, 16'd0, 16'd3, 16'hFFF1, 16'd9));
      send_word(pack_sample(16'h9000, 16'h7000, 16'd0, 16'd2, 16'hFFF2, 16'd4));
      send_word(pack_sample(16'd0, 16'h9000, 16'h7000, 16'd1, 16'hFFF3, 16'd3));
      send_word(pack_sample(16'd0, 16'd0, 16'h9000, 16'd0, 16'hFFF4, 16'd2));
      wait_idle();
      write_csr(CSR_WINDOW, 16'd2);
      send_word(pack_sample(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFF5, 16'd1));
      wait_idle();
   endtask

   // one setting of both registers, then a run of samples
   task automatic run_block(input int n);
      logic [THR_W-1:0]  thr;
      logic [WLEN_W-1:0] wl;
      logic [8:0]        upper;
      wait_idle();
      case ($urandom_range(0, 9))
         0:          thr = '0;
         1:          thr = 16'hFFFF;
         2:          thr = 16'd8192;
         3, 4, 5:    thr = THR_W'($urandom_range(0, 300));
         default:    thr = THR_W'($urandom_range(0, 20000));
      endcase
      case ($urandom_range(0, 9))
         0:          wl = '0;
         1:          wl = 7'd127;
         2:          wl = 7'd75;
         3, 4, 5:    wl = WLEN_W'($urandom_range(1, 4));
         default:    wl = WLEN_W'($urandom_range(1, 20));
      endcase
      upper = 9'($urandom);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_WINDOW, {upper, wl});
      if ($urandom_range(0, 3) == 0)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, CSR_DATA_W'($urandom));
      repeat (n) send_word(wander(last_word));
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
      int target;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = items_sent + PHASE_ITEMS;
      // every sample a one-word window while the receiver holds off
      if (with_hold) begin
         wait_idle();
         write_csr(CSR_THRESHOLD, 16'd0);
         write_csr(CSR_WINDOW, 16'd1);
         hold_requests++;
         repeat (12) send_word({$urandom, $urandom, $urandom});
      end
      while (items_sent < target) run_block($urandom_range(20, 60));
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_tests();
      run_phase(38, 66, 1'b1);
      run_phase(66, 38, 1'b0);
      run_phase(0, 0, 1'b0);
      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: motion_triggered_window_averager.f
src/mtwa_pkg.sv
src/mtwa_div.sv
src/motion_triggered_window_averager.sv
test/motion_triggered_window_averager_test.sv
